@@ rtl/pcrs_pkg.sv @@
// Shared types, register map and table functions for the periodic CQI/RI report scheduler.
`timescale 1ns / 1ps

package pcrs_pkg;

	localparam int ADDR_WIDTH = 5;
	localparam int LOW_WIDTH  = 14;

	typedef enum logic [2:0] {
		REG_CQI_PMI_INDEX   = 3'd0,
		REG_RANK_INDEX      = 3'd1,
		REG_FDD_MODE        = 3'd2,
		REG_PERIODIC_ENABLE = 3'd3,
		REG_RANK_ENABLE     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic [9:0] cqi_pmi_index;
		logic [9:0] rank_index;
		logic       fdd_mode;
		logic       periodic_enable;
		logic       rank_enable;
	} cfg_regs_t;

	// Period is 2^pow2, times five when five is set.
	typedef struct packed {
		logic       valid;
		logic [2:0] pow2;
		logic       five;
		logic [7:0] offset;
	} cqi_map_t;

	typedef struct packed {
		logic       valid;
		logic [2:0] mexp;
		logic [7:0] extra;
	} ri_map_t;

	typedef struct packed {
		logic       cqi_on;
		logic       rank_on;
		logic [3:0] kc;
		logic [3:0] kr;
		logic       five;
		logic [7:0] noff;
		logic [7:0] nri;
	} sched_cfg_t;

	function automatic cqi_map_t map_cqi(input logic [9:0] idx, input logic fdd);
		cqi_map_t m;
		m = '0;
		m.valid = 1'b1;
		if (fdd) begin
			if (idx <= 10'd1) begin
				m.pow2 = 3'd1; m.offset = 8'(idx);
			end else if (idx <= 10'd6) begin
				m.pow2 = 3'd0; m.five = 1'b1; m.offset = 8'(idx - 10'd2);
			end else if (idx <= 10'd16) begin
				m.pow2 = 3'd1; m.five = 1'b1; m.offset = 8'(idx - 10'd7);
			end else if (idx <= 10'd36) begin
				m.pow2 = 3'd2; m.five = 1'b1; m.offset = 8'(idx - 10'd17);
			end else if (idx <= 10'd76) begin
				m.pow2 = 3'd3; m.five = 1'b1; m.offset = 8'(idx - 10'd37);
			end else if (idx <= 10'd156) begin
				m.pow2 = 3'd4; m.five = 1'b1; m.offset = 8'(idx - 10'd77);
			end else if (idx <= 10'd316) begin
				m.pow2 = 3'd5; m.five = 1'b1; m.offset = 8'(idx - 10'd157);
			end else if (idx == 10'd317) begin
				m.valid = 1'b0;
			end else if (idx <= 10'd349) begin
				m.pow2 = 3'd5; m.offset = 8'(idx - 10'd318);
			end else if (idx <= 10'd413) begin
				m.pow2 = 3'd6; m.offset = 8'(idx - 10'd350);
			end else if (idx <= 10'd541) begin
				m.pow2 = 3'd7; m.offset = 8'(idx - 10'd414);
			end else begin
				m.valid = 1'b0;
			end
		end else begin
			if (idx == 10'd0) begin
				m.pow2 = 3'd0; m.offset = 8'd0;
			end else if (idx <= 10'd5) begin
				m.pow2 = 3'd0; m.five = 1'b1; m.offset = 8'(idx - 10'd1);
			end else if (idx <= 10'd15) begin
				m.pow2 = 3'd1; m.five = 1'b1; m.offset = 8'(idx - 10'd6);
			end else if (idx <= 10'd35) begin
				m.pow2 = 3'd2; m.five = 1'b1; m.offset = 8'(idx - 10'd16);
			end else if (idx <= 10'd75) begin
				m.pow2 = 3'd3; m.five = 1'b1; m.offset = 8'(idx - 10'd36);
			end else if (idx <= 10'd155) begin
				m.pow2 = 3'd4; m.five = 1'b1; m.offset = 8'(idx - 10'd76);
			end else if (idx <= 10'd315) begin
				m.pow2 = 3'd5; m.five = 1'b1; m.offset = 8'(idx - 10'd156);
			end else begin
				m.valid = 1'b0;
			end
		end
		return m;
	endfunction

	function automatic ri_map_t map_ri(input logic [9:0] idx);
		ri_map_t m;
		m = '0;
		m.valid = 1'b1;
		if (idx <= 10'd160) begin
			m.mexp = 3'd0; m.extra = 8'(idx);
		end else if (idx <= 10'd321) begin
			m.mexp = 3'd1; m.extra = 8'(idx - 10'd161);
		end else if (idx <= 10'd482) begin
			m.mexp = 3'd2; m.extra = 8'(idx - 10'd322);
		end else if (idx <= 10'd643) begin
			m.mexp = 3'd3; m.extra = 8'(idx - 10'd483);
		end else if (idx <= 10'd804) begin
			m.mexp = 3'd4; m.extra = 8'(idx - 10'd644);
		end else if (idx <= 10'd965) begin
			m.mexp = 3'd5; m.extra = 8'(idx - 10'd805);
		end else begin
			m.valid = 1'b0;
		end
		return m;
	endfunction

	// Sixteen is one modulo five, so the two nibbles are summed and then
	// brought below five by three conditional subtractions.
	function automatic logic [2:0] mod5_byte(input logic [7:0] v);
		logic [4:0] f;
		f = 5'(v[3:0]) + 5'(v[7:4]);
		if (f >= 5'd20) f = f - 5'd20;
		if (f >= 5'd10) f = f - 5'd10;
		if (f >= 5'd5)  f = f - 5'd5;
		return f[2:0];
	endfunction

endpackage

@@ rtl/periodic_cqi_ri_report_scheduler_top.sv @@
// Top level of the periodic CQI/PMI and rank indicator report scheduler.
`timescale 1ns / 1ps
// A word accepted on the slave side is registered in stage 1, moves through stage 2 and
// stage 3, and is offered on the master side from stage 3, whose valid bit drives m_tvalid.
// Throughput: one word per cycle, set by the three-stage check pipeline; a stalled output
// holds its word in the last stage while earlier stages keep filling.
// Reset: arst_n clears all pipeline valid bits and returns the registers to their defaults
// (both indices zero, FDD table selected, reporting and RI reporting disabled).

module periodic_cqi_ri_report_scheduler_top
	import pcrs_pkg::*;
#(
	parameter int COUNT_WIDTH = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// APB-style configuration port.
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ADDR_WIDTH-1:0]      paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	// Slave side.
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [((COUNT_WIDTH+7)/8)*8-1:0] s_tdata, // subframe_count
	// Master side.
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata   // cqi_due, rank_due, zero padding
);

	// The CQI/PMI period always factors as a power of two, optionally times five,
	// and the RI multiplier is a further power of two. A report is therefore due
	// exactly when the shifted count has its low bits clear and, for the periods
	// with a factor of five, its residue modulo five matches the offset residue.
	// The low-bit test uses a fourteen-bit difference, enough for the largest
	// exponent of twelve; the residue of the count comes from a nibble sum since
	// sixteen is one modulo five, so no divider appears anywhere.

	cfg_regs_t  cfg;
	sched_cfg_t dec;
	logic       cqi_due, rank_due;

	pcrs_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The decode is combinational from the registers and is captured into the
	// first pipeline stage with the word, so a write just before a word is seen.
	pcrs_decode u_decode (
		.cfg (cfg),
		.dec (dec)
	);

	pcrs_pipe #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_pipe (
		.clk            (clk),
		.arst_n         (arst_n),
		.dec            (dec),
		.in_valid       (s_tvalid),
		.in_ready       (s_tready),
		.subframe_count (s_tdata[COUNT_WIDTH-1:0]),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.cqi_due        (cqi_due),
		.rank_due       (rank_due)
	);

	assign m_tdata = {6'b0, rank_due, cqi_due};

endmodule

@@ rtl/pcrs_apb_regs.sv @@
// Configuration register file behind the APB-style port.
`timescale 1ns / 1ps

module pcrs_apb_regs
	import pcrs_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [ADDR_WIDTH-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output cfg_regs_t             cfg
);

	cfg_regs_t cfg_q;
	reg_idx_t  idx;
	logic      wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cqi_pmi_index   <= '0;
			cfg_q.rank_index      <= '0;
			cfg_q.fdd_mode        <= 1'b1;
			cfg_q.periodic_enable <= 1'b0;
			cfg_q.rank_enable     <= 1'b0;
		end else if (wr_en) begin
			case (idx)
				REG_CQI_PMI_INDEX:   cfg_q.cqi_pmi_index   <= pwdata[9:0];
				REG_RANK_INDEX:      cfg_q.rank_index      <= pwdata[9:0];
				REG_FDD_MODE:        cfg_q.fdd_mode        <= pwdata[0];
				REG_PERIODIC_ENABLE: cfg_q.periodic_enable <= pwdata[0];
				REG_RANK_ENABLE:     cfg_q.rank_enable     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CQI_PMI_INDEX:   prdata = 32'(cfg_q.cqi_pmi_index);
			REG_RANK_INDEX:      prdata = 32'(cfg_q.rank_index);
			REG_FDD_MODE:        prdata = 32'(cfg_q.fdd_mode);
			REG_PERIODIC_ENABLE: prdata = 32'(cfg_q.periodic_enable);
			REG_RANK_ENABLE:     prdata = 32'(cfg_q.rank_enable);
			default:             prdata = '0;
		endcase
	end

endmodule

@@ rtl/pcrs_decode.sv @@
// Maps the configuration indices to period exponents, offsets and enables.
`timescale 1ns / 1ps

module pcrs_decode
	import pcrs_pkg::*;
(
	input  cfg_regs_t  cfg,
	output sched_cfg_t dec
);

	cqi_map_t cm;
	ri_map_t  rm;

	always_comb begin
		cm = map_cqi(cfg.cqi_pmi_index, cfg.fdd_mode);
		rm = map_ri(cfg.rank_index);
		dec.cqi_on  = cfg.periodic_enable & cm.valid;
		dec.rank_on = cfg.periodic_enable & cm.valid & cfg.rank_enable & rm.valid;
		dec.kc      = 4'(cm.pow2);
		// The RI multiplier is a power of two, so it only adds to the exponent.
		dec.kr      = 4'(cm.pow2) + 4'(rm.mexp);
		dec.five    = cm.five;
		dec.noff    = cm.offset;
		dec.nri     = rm.extra;
	end

endmodule

@@ rtl/pcrs_pipe.sv @@
// Three-stage pipeline that tests one subframe number against both report periods.
`timescale 1ns / 1ps

module pcrs_pipe
	import pcrs_pkg::*;
#(
	parameter int COUNT_WIDTH = 14
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sched_cfg_t             dec,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [COUNT_WIDTH-1:0] subframe_count,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   cqi_due,
	output logic                   rank_due
);

	localparam int NIB_RAW = (COUNT_WIDTH + 3) / 4;
	localparam int NIB     = (NIB_RAW > 4) ? NIB_RAW : 4;
	localparam int EW      = NIB * 4;

	// Stage 1: count and decoded configuration.
	logic             v_s1;
	logic [EW-1:0]    t_s1;
	sched_cfg_t       dec_s1;
	// Stage 2: nibble sum, low-part differences and offset residues.
	logic             v_s2;
	logic [7:0]       sum_s2;
	logic [LOW_WIDTH-1:0] yc_s2, yr_s2;
	logic [2:0]       rc_s2, rn_s2;
	logic [3:0]       kc_s2, kr_s2;
	logic             five_s2, cqi_on_s2, rank_on_s2;
	// Stage 3: results.
	logic             v_s3, cqi_s3, rank_s3;

	logic rdy1, rdy2, rdy3;
	logic [7:0] nsum;
	logic [LOW_WIDTH-1:0] t_low;
	logic [2:0] tres, rr;
	logic [LOW_WIDTH-1:0] mask_c, mask_r;
	logic zc, zr;

	assign rdy3     = !v_s3 | out_ready;
	assign rdy2     = !v_s2 | rdy3;
	assign rdy1     = !v_s1 | rdy2;
	assign in_ready = rdy1;

	always_comb begin
		nsum = '0;
		for (int i = 0; i < NIB; i++) begin
			nsum = nsum + 8'(t_s1[4*i +: 4]);
		end
	end

	assign t_low = t_s1[LOW_WIDTH-1:0];

	always_comb begin
		tres   = mod5_byte(sum_s2);
		rr     = (rc_s2 >= rn_s2) ? (rc_s2 - rn_s2) : (rc_s2 + 3'd5 - rn_s2);
		mask_c = ~({LOW_WIDTH{1'b1}} << kc_s2);
		mask_r = ~({LOW_WIDTH{1'b1}} << kr_s2);
		zc     = (yc_s2 & mask_c) == '0;
		zr     = (yr_s2 & mask_r) == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			t_s1   <= EW'(subframe_count);
			dec_s1 <= dec;
		end
		if (rdy2 && v_s1) begin
			sum_s2     <= nsum;
			yc_s2      <= t_low - LOW_WIDTH'(dec_s1.noff);
			yr_s2      <= t_low + LOW_WIDTH'(dec_s1.nri) - LOW_WIDTH'(dec_s1.noff);
			rc_s2      <= mod5_byte(dec_s1.noff);
			rn_s2      <= mod5_byte(dec_s1.nri);
			kc_s2      <= dec_s1.kc;
			kr_s2      <= dec_s1.kr;
			five_s2    <= dec_s1.five;
			cqi_on_s2  <= dec_s1.cqi_on;
			rank_on_s2 <= dec_s1.rank_on;
		end
		if (rdy3 && v_s2) begin
			cqi_s3  <= cqi_on_s2 & zc & (!five_s2 | (tres == rc_s2));
			rank_s3 <= rank_on_s2 & zr & (!five_s2 | (tres == rr));
		end
	end

	assign out_valid = v_s3;
	assign cqi_due   = cqi_s3;
	assign rank_due  = rank_s3;

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the periodic CQI/PMI and rank indicator report scheduler.
`timescale 1ns / 1ps

module testbench;
	import pcrs_pkg::*;

	localparam int COUNT_W      = 14;
	localparam int TDATA_W      = ((COUNT_W + 7) / 8) * 8;
	localparam int PIPE_LATENCY = 3;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TARGET_ITEMS = 1200;
	localparam int LONG_HOLD    = 400;
	localparam int MAX_COUNT    = (1 << COUNT_W) - 1;
	localparam int MAX_REPORTS  = 10;

	// Register slots that the map leaves unused; writes to them must change nothing.
	localparam int SPARE_REG_A = 5;
	localparam int SPARE_REG_B = 7;

	// Period tables as inclusive index ranges; the offset is the index minus the range base.
	localparam int FDD_LO     [10] = '{0, 2, 7, 17, 37, 77, 157, 318, 350, 414};
	localparam int FDD_HI     [10] = '{1, 6, 16, 36, 76, 156, 316, 349, 413, 541};
	localparam int FDD_PERIOD [10] = '{2, 5, 10, 20, 40, 80, 160, 32, 64, 128};
	localparam int TDD_LO     [7]  = '{0, 1, 6, 16, 36, 76, 156};
	localparam int TDD_HI     [7]  = '{0, 5, 15, 35, 75, 155, 315};
	localparam int TDD_PERIOD [7]  = '{1, 5, 10, 20, 40, 80, 160};
	// The RI table is six blocks of 161 indices, each doubling the multiplier.
	localparam int RI_BLOCK   = 161;
	localparam int RI_BLOCKS  = 6;

	localparam int CQI_EDGES  [21] = '{0, 1, 2, 5, 6, 7, 15, 16, 35, 36, 76, 156, 157, 315,
		316, 317, 318, 349, 414, 541, 542};
	localparam int RANK_EDGES [14] = '{0, 160, 161, 321, 322, 482, 483, 643, 644, 804, 805,
		965, 966, 1023};
	localparam int COUNT_EDGES [4] = '{0, 10239, 10240, MAX_COUNT};

	typedef struct {
		logic [COUNT_W-1:0] subframe;
		bit                 cqi_due;
		bit                 rank_due;
	} due_word_t;

	// Keeps its own copy of the registers, predicts the report flags for every accepted
	// subframe and checks each returned word against the oldest prediction.
	class report_due_board;
		logic [9:0] cqi_pmi_index;
		logic [9:0] rank_index;
		bit         fdd_mode;
		bit         periodic_enable;
		bit         rank_enable;
		due_word_t  due_queue[$];
		int         fail_count;
		int         checked;
		int         cqi_seen;
		int         rank_seen;

		function new();
			cqi_pmi_index   = '0;
			rank_index      = '0;
			fdd_mode        = 1'b1;
			periodic_enable = 1'b0;
			rank_enable     = 1'b0;
			fail_count      = 0;
			checked         = 0;
			cqi_seen        = 0;
			rank_seen       = 0;
		endfunction

		function void write_reg(int idx, logic [31:0] value);
			case (idx)
				REG_CQI_PMI_INDEX:   cqi_pmi_index   = value[9:0];
				REG_RANK_INDEX:      rank_index      = value[9:0];
				REG_FDD_MODE:        fdd_mode        = value[0];
				REG_PERIODIC_ENABLE: periodic_enable = value[0];
				REG_RANK_ENABLE:     rank_enable     = value[0];
				default: ;
			endcase
		endfunction

		// Works out the CQI period and offset and the combined RI period and extra offset.
		function void decode(output bit cqi_ok, output int unsigned np, output int unsigned noff,
				output bit ri_ok, output int unsigned p, output int unsigned nri);
			int unsigned idx;
			int unsigned blk;
			cqi_ok = 1'b0;
			ri_ok  = 1'b0;
			np     = 1;
			noff   = 0;
			p      = 1;
			nri    = 0;
			idx    = cqi_pmi_index;
			if (fdd_mode) begin
				for (int i = 0; i < 10; i++)
					if (idx >= FDD_LO[i] && idx <= FDD_HI[i]) begin
						cqi_ok = 1'b1;
						np     = FDD_PERIOD[i];
						noff   = idx - FDD_LO[i];
					end
			end else begin
				for (int i = 0; i < 7; i++)
					if (idx >= TDD_LO[i] && idx <= TDD_HI[i]) begin
						cqi_ok = 1'b1;
						np     = TDD_PERIOD[i];
						noff   = idx - TDD_LO[i];
					end
			end
			cqi_ok = cqi_ok && periodic_enable;
			blk = rank_index / RI_BLOCK;
			if (cqi_ok && rank_enable && blk < RI_BLOCKS) begin
				ri_ok = 1'b1;
				p     = np << blk;
				nri   = rank_index - RI_BLOCK * blk;
			end
		endfunction

		function void note_subframe(logic [COUNT_W-1:0] count);
			due_word_t   e;
			bit          cqi_ok;
			bit          ri_ok;
			int unsigned np;
			int unsigned noff;
			int unsigned p;
			int unsigned nri;
			int unsigned t;
			decode(cqi_ok, np, noff, ri_ok, p, nri);
			t          = count;
			e.subframe = count;
			e.cqi_due  = cqi_ok && ((t + np - noff) % np == 0);
			e.rank_due = ri_ok && ((t + nri + p - noff) % p == 0);
			due_queue.push_back(e);
		endfunction

		function void note_failure(string msg);
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$display("[%0t] MISMATCH: %s", $time, msg);
		endfunction

		function void check_report(logic [7:0] word);
			due_word_t e;
			if (due_queue.size() == 0) begin
				note_failure($sformatf("report word %h arrived with nothing outstanding", word));
				return;
			end
			e = due_queue.pop_front();
			checked++;
			cqi_seen  += e.cqi_due;
			rank_seen += e.rank_due;
			if (word[0] !== e.cqi_due)
				note_failure($sformatf("subframe %0d cqi_due expected %0b got %b",
					e.subframe, e.cqi_due, word[0]));
			if (word[1] !== e.rank_due)
				note_failure($sformatf("subframe %0d rank_due expected %0b got %b",
					e.subframe, e.rank_due, word[1]));
		endfunction

		function int pending();
			return due_queue.size();
		endfunction

		function void flag_leftovers();
			foreach (due_queue[i])
				note_failure($sformatf("no report word came for subframe %0d",
					due_queue[i].subframe));
		endfunction
	endclass

	logic                    clk;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_WIDTH-1:0]   paddr;
	logic [31:0]             pwdata;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    s_tvalid;
	logic                    s_tready;
	logic [TDATA_W-1:0]      s_tdata;  // subframe_count, zero padding
	logic                    m_tvalid;
	logic                    m_tready;
	logic [7:0]              m_tdata;  // cqi_due, rank_due, zero padding

	report_due_board board;
	int  items_sent;
	int  configs_loaded;
	// Set for whole phases in which neither side idles.
	bit  no_idle;
	// Raised by the stimulus to make the receiver hold off for a long stretch.
	bit  hold_off_request;

	periodic_cqi_ri_report_scheduler_top #(
		.COUNT_WIDTH(COUNT_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// One APB write: a setup phase, an access phase, then the bus is released before return
	// so that back-to-back writes never drive psel twice in one time step.
	task automatic apb_write(input int idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_WIDTH'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		board.write_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Every register is written, with random junk above its width that must be dropped.
	task automatic load_config(input logic [9:0] cqi, input logic [9:0] rank, input bit fdd,
			input bit periodic_on, input bit rank_on);
		apb_write(REG_CQI_PMI_INDEX,   {22'($urandom()), cqi});
		apb_write(REG_RANK_INDEX,      {22'($urandom()), rank});
		apb_write(REG_FDD_MODE,        {31'($urandom()), fdd});
		apb_write(REG_PERIODIC_ENABLE, {31'($urandom()), periodic_on});
		apb_write(REG_RANK_ENABLE,     {31'($urandom()), rank_on});
		configs_loaded++;
	endtask

	// Offers one subframe word, idling at random beforehand, and returns once it is taken.
	task automatic send_subframe(input logic [COUNT_W-1:0] count);
		while (!no_idle && $urandom_range(0, 99) < 28) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_W'(count);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_subframe(count);
		items_sent++;
	endtask

	// Stops offering words and waits until every predicted report has come back, plus the
	// pipeline depth, so that the registers can be rewritten safely.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (PIPE_LATENCY) @(posedge clk);
	endtask

	// When reports are enabled, many subframes are chosen to land on a CQI or an RI occasion
	// of the current setting, since uniformly random counts would almost never hit the long periods.
	function automatic logic [COUNT_W-1:0] pick_subframe();
		bit          cqi_ok;
		bit          ri_ok;
		int unsigned np;
		int unsigned noff;
		int unsigned p;
		int unsigned nri;
		int unsigned base;
		int unsigned r;
		board.decode(cqi_ok, np, noff, ri_ok, p, nri);
		r = $urandom_range(0, 99);
		if (cqi_ok && r < 35) begin
			base = noff;
			return COUNT_W'(base + np * $urandom_range(0, (MAX_COUNT - base) / np));
		end
		if (ri_ok && r < 60) begin
			base = (noff + p - (nri % p)) % p;
			return COUNT_W'(base + p * $urandom_range(0, (MAX_COUNT - base) / p));
		end
		if (r < 68)
			return COUNT_W'(COUNT_EDGES[$urandom_range(0, 3)]);
		return COUNT_W'($urandom_range(0, MAX_COUNT));
	endfunction

	task automatic random_config();
		bit          fdd;
		logic [9:0]  cqi;
		logic [9:0]  rank;
		int unsigned r;
		fdd = $urandom_range(0, 1);
		r = $urandom_range(0, 99);
		if (r < 25)
			cqi = 10'(CQI_EDGES[$urandom_range(0, 20)]);
		else if (r < 80)
			cqi = 10'($urandom_range(0, fdd ? 541 : 315));
		else
			cqi = 10'($urandom_range(0, 1023));
		r = $urandom_range(0, 99);
		if (r < 25)
			rank = 10'(RANK_EDGES[$urandom_range(0, 13)]);
		else if (r < 85)
			rank = 10'($urandom_range(0, 965));
		else
			rank = 10'($urandom_range(0, 1023));
		if ($urandom_range(0, 9) == 0)
			apb_write($urandom_range(0, 1) ? SPARE_REG_A : SPARE_REG_B, $urandom());
		load_config(cqi, rank, fdd, $urandom_range(0, 99) < 88, $urandom_range(0, 99) < 75);
	endtask

	// Receiver: checks each accepted report word, then chooses the next ready level.
	// A requested hold-off keeps ready low for a long count so the pipeline fills up
	// and pushes back on the sender.
	initial begin
		int hold_left;
		hold_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				board.check_report(m_tdata);
			if (hold_off_request) begin
				hold_off_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= no_idle || ($urandom_range(0, 99) >= 28);
			end
		end
	end

	// Watchdog: ends the run if no word moves on any port for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
				quiet = 0;
			else
				quiet++;
		end
		$display("[%0t] TIMEOUT: no word moved for %0d cycles", $time, QUIET_LIMIT);
		$display("periodic_cqi_ri_report_scheduler_top test failed");
		$finish;
	end

	initial begin
		int phase;
		int quota;
		board            = new();
		items_sent       = 0;
		configs_loaded   = 0;
		no_idle          = 1'b0;
		hold_off_request = 1'b0;
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at their reset values: reporting is disabled, so nothing is due.
		send_subframe(0);
		send_subframe(MAX_COUNT);
		drain();

		// Shortest FDD period with RI on, across the count extremes and past 10239.
		load_config(10'd0, 10'd0, 1'b1, 1'b1, 1'b1);
		send_subframe(0);
		send_subframe(1);
		send_subframe(2);
		send_subframe(10239);
		send_subframe(10240);
		send_subframe(MAX_COUNT);
		drain();

		// Writes to unused slots must be ignored; index 317 is reserved in the FDD table.
		apb_write(SPARE_REG_A, 32'hFFFF_FFFF);
		apb_write(SPARE_REG_B, 32'hFFFF_FFFF);
		load_config(10'd317, 10'd0, 1'b1, 1'b1, 1'b1);
		send_subframe(0);
		send_subframe(317);
		drain();

		// Highest valid CQI and RI indices: period 128 with multiplier 32 and extra 160.
		load_config(10'd541, 10'd965, 1'b1, 1'b1, 1'b1);
		send_subframe(127);
		send_subframe(4063);
		send_subframe(MAX_COUNT);
		drain();

		// Top of the FDD index range is reserved, as is the top of the RI range.
		load_config(10'd1023, 10'd0, 1'b1, 1'b1, 1'b1);
		send_subframe(0);
		drain();
		load_config(10'd0, 10'd1023, 1'b1, 1'b1, 1'b1);
		send_subframe(0);
		drain();

		// TDD: period one with the first reserved RI index.
		load_config(10'd0, 10'd966, 1'b0, 1'b1, 1'b1);
		send_subframe(0);
		send_subframe(5);
		drain();

		// Last valid TDD index with RI reporting switched off.
		load_config(10'd315, 10'd160, 1'b0, 1'b1, 1'b0);
		send_subframe(159);
		send_subframe(319);
		drain();

		// First reserved TDD index.
		load_config(10'd316, 10'd0, 1'b0, 1'b1, 1'b1);
		send_subframe(0);
		drain();

		// Random phases, each with a fresh setting. One phase runs with no idling at all,
		// and another holds the receiver off while the sender keeps offering words.
		phase = 0;
		while (items_sent < TARGET_ITEMS) begin
			random_config();
			no_idle = (phase == 1);
			quota = $urandom_range(20, 70);
			if (phase == 1)
				quota = 150;
			if (phase == 3) begin
				quota = 150;
				hold_off_request = 1'b1;
			end
			repeat (quota) send_subframe(pick_subframe());
			drain();
			phase++;
		end
		no_idle = 1'b0;

		repeat (PIPE_LATENCY + 5) @(posedge clk);
		board.flag_leftovers();
		$display("Checked %0d report words over %0d register settings: %0d CQI and %0d RI due.",
			board.checked, configs_loaded, board.cqi_seen, board.rank_seen);
		$display("Both tables, reserved indices, disabled reporting and wrapped counts were run.");
		if (board.fail_count == 0) begin
			$display("periodic_cqi_ri_report_scheduler_top test passed");
		end else begin
			$display("%0d mismatches in total", board.fail_count);
			$display("periodic_cqi_ri_report_scheduler_top test failed");
		end
		$finish;
	end

endmodule

@@ periodic_cqi_ri_report_scheduler_top.f @@
rtl/pcrs_pkg.sv
rtl/pcrs_apb_regs.sv
rtl/pcrs_decode.sv
rtl/pcrs_pipe.sv
rtl/periodic_cqi_ri_report_scheduler_top.sv
dv/testbench.sv
